[src/kti_pkg.sv]
`default_nettype none
package kti_pkg;
    typedef enum logic [2:0] {
        K_ADD = 3'd0, K_REMOVE = 3'd1, K_VALUE = 3'd2, K_PREV = 3'd3, K_NEXT = 3'd4
    } t_kind;
    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_SAME = 3'd1, ST_NOTFOUND = 3'd2, ST_FULL = 3'd3, ST_EMPTY = 3'd4
    } t_status;
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SCAN_WAIT, S_FIX, S_SHIFT_RD, S_SHIFT_WR, S_WRITE,
        S_LERP_RD, S_LERP_A, S_LERP_B, S_MUL, S_DIV, S_ADJ, S_OUT
    } t_state;
    localparam int KEY_W = 65;  // time 32 + value 32 + hold 1
endpackage
`default_nettype wire

[src/keyframe_table_interpolator.sv]
// channel  dir  tdata fields (low bit up)                               tuser
// s_axis   in   kind[2:0] channel[6:3] time_ms[38:7] new_value[70:39]    -
//               hold[71] fallback[103:72], 104 bits in all
// m_axis   out  status[2:0] result_value[34:3] result_time[67:35], pad 72  -
// One item at a time: accept, scan every stored key (a read and a wait each),
// decide. Insert/remove shift each moved key with a read and a write;
// interpolation adds key reads and setup, one 32x32 multiply, a 32-step restoring divide and an adjust.
// Reset (i_rst_n low, synchronous) empties all channels; RAM contents stay.
// A stalled result sits in the output register; the next item only waits
// for it when its own result is ready.
`default_nettype none
module keyframe_table_interpolator #(
    parameter int CHANNELS = 16,
    parameter int KEYS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [103:0] s_axis_tdata,  // kind, channel, time_ms, new_value, hold, fallback
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata   // status, result_value, result_time
);
    import kti_pkg::*;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW = $clog2(KEYS + 1);
    localparam int AW = $clog2(CHANNELS * KEYS);

    t_state r_st, n_st;
    logic [NW-1:0] r_cnt [CHANNELS];
    logic [2:0]  r_kind;
    logic [3:0]  r_ch;
    logic [31:0] r_t, r_nv, r_fb;
    logic        r_hold, r_valid;
    logic [NW-1:0] r_n, r_i, r_j;
    logic        r_found;      // equal time seen / prev or next found
    logic [NW-1:0] r_pos;      // first key at or after the item time
    logic        r_posset;
    logic [KEY_W-1:0] r_a, r_b, r_key;
    logic [31:0] r_mag, r_dt, r_span;
    logic [31:0] r_rem, r_q;
    logic [4:0]  r_step;
    logic        r_neg;
    t_status     r_res_st;
    logic [31:0] r_res_rv;
    logic [32:0] r_res_rt;
    t_status     r_ost;
    logic [31:0] r_orv;
    logic [32:0] r_ort;
    logic        r_ovalid;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [KEY_W-1:0] wdata, rdata;
    logic [CW-1:0] chx;
    logic [31:0] rd_t, rd_v;
    logic        in_ok;
    logic [NW-1:0] in_n;
    logic        ld_out;
    t_state      fx_nx;
    t_status     fx_st;
    logic [31:0] fx_rv;
    logic [32:0] fx_rt;
    logic [NW-1:0] fx_j;
    logic        cnt_we;
    logic [NW-1:0] cnt_nx;
    logic [32:0] lp_diff, lp_mag;
    logic [63:0] prod;
    logic [32:0] dv_sh;
    logic [33:0] dv_sub;

    kti_ram #(.WIDTH(KEY_W), .DEPTH(CHANNELS * KEYS)) u_keys (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    function automatic logic [AW-1:0] addr(input logic [CW-1:0] c, input logic [NW-1:0] k);
        return AW'(int'(c) * KEYS + int'(k));
    endfunction

    assign chx = CW'(r_ch);
    assign rd_t = rdata[31:0];
    assign rd_v = rdata[63:32];
    assign in_ok = 32'(s_axis_tdata[6:3]) < CHANNELS;
    assign in_n = in_ok ? r_cnt[CW'(s_axis_tdata[6:3])] : '0;

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {4'd0, r_ort, r_orv, r_ost};
    assign ld_out = (r_st == S_OUT) && (!r_ovalid || m_axis_tready);

    // interpolation datapath
    assign lp_diff = {rd_v[31], rd_v} - {r_a[63], r_a[63:32]};
    assign lp_mag = lp_diff[32] ? -lp_diff : lp_diff;
    assign prod = 64'(r_mag) * 64'(r_dt);
    assign dv_sh = {r_rem, r_q[31]};
    assign dv_sub = {1'b0, dv_sh} - {2'b00, r_span};

    // decision after the scan
    always_comb begin
        fx_nx = S_OUT;
        fx_st = ST_NOTFOUND;
        fx_rv = '0;
        fx_rt = '0;
        fx_j = r_pos;
        cnt_we = 1'b0;
        cnt_nx = r_n;
        unique case (r_kind)
            K_ADD: begin
                if (!r_valid) fx_st = ST_FULL;
                else if (r_found) begin
                    if (r_key[63:32] == r_nv) fx_st = ST_SAME;
                    else begin
                        fx_st = ST_OK;
                        fx_nx = S_WRITE;
                    end
                end else if (r_n >= NW'(KEYS)) fx_st = ST_FULL;
                else begin
                    fx_st = ST_OK;
                    cnt_we = 1'b1;
                    cnt_nx = r_n + 1'b1;
                    fx_j = r_n;
                    fx_nx = (r_pos == r_n) ? S_WRITE : S_SHIFT_RD;
                end
            end
            K_REMOVE: if (r_found) begin
                fx_st = ST_OK;
                cnt_we = 1'b1;
                cnt_nx = r_n - 1'b1;
                fx_j = r_pos;
                fx_nx = (r_pos + 1'b1 < r_n) ? S_SHIFT_RD : S_OUT;
            end
            K_VALUE: begin
                if (r_n == '0) begin
                    fx_st = ST_EMPTY;
                    fx_rv = r_fb;
                end else begin
                    fx_st = ST_OK;
                    if (r_t <= r_a[31:0]) fx_rv = r_a[63:32];
                    else if (r_t >= r_b[31:0]) fx_rv = r_b[63:32];
                    else fx_nx = S_LERP_RD;
                end
            end
            K_PREV, K_NEXT: begin
                fx_rt = '1;
                if (r_n == '0) fx_st = ST_EMPTY;
                else if (r_found) begin
                    fx_st = ST_OK;
                    fx_rt = {1'b0, r_key[31:0]};
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        we = 1'b0;
        waddr = addr(chx, r_i);
        wdata = {r_hold, r_nv, r_t};
        raddr = addr(chx, r_i);
        unique case (r_st)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_st = S_SCAN;
            S_SCAN: n_st = (r_i < r_n) ? S_SCAN_WAIT : S_FIX;
            S_SCAN_WAIT: n_st = S_SCAN;
            S_FIX: n_st = fx_nx;
            S_SHIFT_RD: begin
                raddr = addr(chx, (r_kind == K_ADD) ? r_j - 1'b1 : r_j + 1'b1);
                n_st = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                we = 1'b1;
                waddr = addr(chx, r_j);
                wdata = rdata;
                if (r_kind == K_ADD) n_st = (r_j - 1'b1 == r_pos) ? S_WRITE : S_SHIFT_RD;
                else n_st = (r_j + NW'(2) >= r_n) ? S_OUT : S_SHIFT_RD;
            end
            S_WRITE: begin
                we = 1'b1;
                waddr = addr(chx, r_pos);
                // an update keeps the stored hold flag
                wdata = r_found ? {r_key[64], r_nv, r_t} : {r_hold, r_nv, r_t};
                n_st = S_OUT;
            end
            S_LERP_RD: begin
                raddr = addr(chx, r_pos - 1'b1);
                n_st = S_LERP_A;
            end
            S_LERP_A: begin
                raddr = addr(chx, r_pos);
                n_st = S_LERP_B;
            end
            S_LERP_B: n_st = r_a[64] ? S_OUT : S_MUL;
            S_MUL: n_st = S_DIV;
            S_DIV: n_st = (r_step == '0) ? S_ADJ : S_DIV;
            S_ADJ: n_st = S_OUT;
            S_OUT: n_st = ld_out ? S_IDLE : S_OUT;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) r_cnt[c] <= '0;
        end else begin
            if (ld_out) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_st == S_FIX && cnt_we) r_cnt[chx] <= cnt_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                r_kind <= s_axis_tdata[2:0];
                r_ch <= s_axis_tdata[6:3];
                r_t <= s_axis_tdata[38:7];
                r_nv <= s_axis_tdata[70:39];
                r_hold <= s_axis_tdata[71];
                r_fb <= s_axis_tdata[103:72];
                r_valid <= in_ok;
                r_n <= in_n;
                r_i <= '0;
                r_found <= 1'b0;
                r_posset <= 1'b0;
                r_pos <= in_n;
            end
            S_SCAN_WAIT: begin
                // rdata = entry r_i
                r_i <= r_i + 1'b1;
                if (r_i == '0) r_a <= rdata;
                r_b <= rdata;  // last entry once scan ends
                if (rd_t >= r_t && !r_posset) begin
                    r_posset <= 1'b1;
                    r_pos <= r_i;
                end
                unique case (r_kind)
                    K_ADD, K_REMOVE: if (rd_t == r_t) begin
                        r_found <= 1'b1;
                        r_key <= rdata;
                    end
                    K_PREV: if (rd_t < r_t) begin
                        r_found <= 1'b1;
                        r_key <= rdata;
                    end
                    K_NEXT: if (rd_t > r_t && !r_found) begin
                        r_found <= 1'b1;
                        r_key <= rdata;
                    end
                    default: ;
                endcase
            end
            S_FIX: begin
                r_res_st <= fx_st;
                r_res_rv <= fx_rv;
                r_res_rt <= fx_rt;
                r_j <= fx_j;
            end
            S_SHIFT_WR: r_j <= (r_kind == K_ADD) ? r_j - 1'b1 : r_j + 1'b1;
            S_LERP_A: r_a <= rdata;
            S_LERP_B: begin
                // rdata = key b; a hold key answers with its own value
                r_res_rv <= r_a[63:32];
                r_neg <= lp_diff[32];
                r_mag <= lp_mag[31:0];
                r_span <= rd_t - r_a[31:0];
                r_dt <= r_t - r_a[31:0];
            end
            S_MUL: begin
                // quotient fits 32 bits since dt <= span
                r_rem <= prod[63:32];
                r_q <= prod[31:0];
                r_step <= 5'd31;
            end
            S_DIV: begin
                if (!dv_sub[33]) r_rem <= dv_sub[31:0];
                else r_rem <= dv_sh[31:0];
                r_q <= {r_q[30:0], !dv_sub[33]};
                r_step <= r_step - 1'b1;
            end
            S_ADJ: r_res_rv <= r_neg ? r_a[63:32] - r_q : r_a[63:32] + r_q;
            S_OUT: if (ld_out) begin
                r_ost <= r_res_st;
                r_orv <= r_res_rv;
                r_ort <= r_res_rt;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[src/kti_ram.sv]
`default_nettype none
module kti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
